// ===== design/link_controller_register_file_core_assert.svh =====
// Assertion macros for the link controller register file.
// Depends on nothing; included by the top level only.
`ifndef LINK_CONTROLLER_REGISTER_FILE_CORE_ASSERT_SVH
`define LINK_CONTROLLER_REGISTER_FILE_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define LCRF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcrf assertion failed");
// Next-cycle implication under reset.
`define LCRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcrf assertion failed");
`else
`define LCRF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define LCRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/lcrf_pkg.sv =====
// Shared types, constants and the address decoder of the link controller register file.
// Depends on nothing; used by the store and the top level.
package lcrf_pkg;

    localparam int WINDOW_BYTES = 2048;

    // Fixed words.
    localparam logic [31:0] VERSION_WORD      = 32'h0001_0000;
    localparam logic [31:0] BUS_NAME_WORD     = 32'h3133_3934;
    localparam logic [31:0] BUS_OPTIONS_RESET = 32'h0000_a002;
    localparam logic [31:0] SOFT_RESET_BIT    = 32'h0001_0000;
    localparam logic [31:0] MASTER_ENABLE     = 32'h8000_0000;
    localparam logic [31:0] PHY_ABSENT        = 32'hffff_ffff;

    // Fixed register offsets.
    localparam logic [10:0] ADDR_VERSION     = 11'h000;
    localparam logic [10:0] ADDR_BUS_NAME    = 11'h01c;
    localparam logic [10:0] ADDR_BUS_OPTIONS = 11'h020;
    localparam logic [10:0] ADDR_GUID_HI     = 11'h024;
    localparam logic [10:0] ADDR_GUID_LO     = 11'h028;
    localparam logic [10:0] ADDR_PHY_CONTROL = 11'h0ec;

    // Main store layout: plain registers, then masks, then bus options.
    localparam int NUM_PLAIN   = 16;
    localparam int NUM_MASKS   = 14;
    localparam int MAIN_DEPTH  = 32;
    localparam int MAIN_IDX_W  = $clog2(MAIN_DEPTH);
    localparam logic [MAIN_IDX_W-1:0] MASK_BASE     = MAIN_IDX_W'(NUM_PLAIN);
    localparam logic [MAIN_IDX_W-1:0] IDX_CONTROL   = MAIN_IDX_W'(NUM_PLAIN + 0);
    localparam logic [MAIN_IDX_W-1:0] IDX_INT_EVENT = MAIN_IDX_W'(NUM_PLAIN + 3);
    localparam logic [MAIN_IDX_W-1:0] IDX_INT_MASK  = MAIN_IDX_W'(NUM_PLAIN + 4);
    localparam logic [MAIN_IDX_W-1:0] IDX_BUS_OPT   = MAIN_IDX_W'(NUM_PLAIN + NUM_MASKS);

    localparam logic [10:0] PLAIN_OFFSETS [NUM_PLAIN] = '{
        11'h008, 11'h00c, 11'h010, 11'h014, 11'h018, 11'h034, 11'h038, 11'h03c,
        11'h064, 11'h068, 11'h0b0, 11'h0b4, 11'h0b8, 11'h0dc, 11'h0f0, 11'h120
    };

    // Set addresses of the masks; the clear address is four above.
    localparam logic [10:0] MASK_OFFSETS [NUM_MASKS] = '{
        11'h050, 11'h070, 11'h078, 11'h080, 11'h088, 11'h090, 11'h098,
        11'h0a0, 11'h0a8, 11'h0e0, 11'h100, 11'h108, 11'h110, 11'h118
    };

    // Access kinds.
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_CONST = 3'd1;
    localparam logic [2:0] K_PLAIN = 3'd2;
    localparam logic [2:0] K_MASK  = 3'd3;
    localparam logic [2:0] K_GUID  = 3'd4;

    typedef struct packed {
        logic [2:0]            kind;
        logic [MAIN_IDX_W-1:0] idx;
        logic                  clr;
        logic [31:0]           value;
    } dec_t;

    typedef struct packed {
        logic                  en;
        logic [MAIN_IDX_W-1:0] main_idx;
        logic                  id_idx;
    } store_rd_t;

    typedef struct packed {
        logic                  main_we;
        logic [MAIN_IDX_W-1:0] main_idx;
        logic [31:0]           main_wdata;
        logic                  id_we;
        logic                  id_idx;
        logic [31:0]           id_wdata;
        logic                  clear_all;
    } store_wr_t;

    // Decodes one byte offset into the kind of access and its store slot.
    function automatic dec_t decode(input logic [10:0] a);
        dec_t d;
        d = '{kind: K_NONE, idx: '0, clr: 1'b0, value: '0};
        if ({2'b00, a} < 13'(WINDOW_BYTES))
        begin
            if (a == ADDR_VERSION)
            begin
                d.kind  = K_CONST;
                d.value = VERSION_WORD;
            end
            if (a == ADDR_BUS_NAME)
            begin
                d.kind  = K_CONST;
                d.value = BUS_NAME_WORD;
            end
            if (a == ADDR_PHY_CONTROL)
            begin
                d.kind  = K_CONST;
                d.value = PHY_ABSENT;
            end
            if (a == ADDR_BUS_OPTIONS)
            begin
                d.kind = K_PLAIN;
                d.idx  = IDX_BUS_OPT;
            end
            if (a == ADDR_GUID_HI)
            begin
                d.kind = K_GUID;
                d.idx  = '0;
            end
            if (a == ADDR_GUID_LO)
            begin
                d.kind = K_GUID;
                d.idx  = MAIN_IDX_W'(1);
            end
            for (int i = 0; i < NUM_PLAIN; i++)
            begin
                if (a == PLAIN_OFFSETS[i])
                begin
                    d.kind = K_PLAIN;
                    d.idx  = MAIN_IDX_W'(i);
                end
            end
            for (int i = 0; i < NUM_MASKS; i++)
            begin
                if ({a[10:3], 1'b0, a[1:0]} == MASK_OFFSETS[i])
                begin
                    d.kind = K_MASK;
                    d.idx  = MAIN_IDX_W'(NUM_PLAIN + i);
                    d.clr  = a[2];
                end
            end
        end
        return d;
    endfunction

endpackage

// ===== design/lcrf_if.sv =====
// Handshake channels of the link controller register file: access items and result items.
// Depends on nothing.
interface lcrf_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [10:0] address;
    logic [31:0] write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink (input valid, action, address, write_data, output ready);
endinterface

interface lcrf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_level;

    modport source (output valid, read_data, irq_level, input ready);
    modport sink (input valid, read_data, irq_level, output ready);
endinterface

// ===== design/lcrf_store.sv =====
// Register storage: main memory with per-entry valid bits, and the GUID memory.
// Depends on lcrf_pkg.
module lcrf_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcrf_pkg::store_rd_t                 rd,
    input  lcrf_pkg::store_wr_t                 wr,
    output logic [31:0]                         main_rdata,
    output logic [31:0]                         id_rdata
);

    logic [31:0] main_mem [lcrf_pkg::MAIN_DEPTH];
    logic [31:0] id_mem [2];

    logic [lcrf_pkg::MAIN_DEPTH-1:0] main_valid_reg;
    logic [lcrf_pkg::MAIN_DEPTH-1:0] main_valid_next;
    logic [1:0]                      id_valid_reg;

    logic [31:0]                     main_raw_reg;
    logic                            main_hit_reg;
    logic [lcrf_pkg::MAIN_IDX_W-1:0] main_idx_reg;
    logic [31:0]                     id_raw_reg;
    logic                            id_hit_reg;

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr.main_we)
        begin
            main_mem[wr.main_idx] <= wr.main_wdata;
        end
        if (wr.id_we)
        begin
            id_mem[wr.id_idx] <= wr.id_wdata;
        end
        if (rd.en)
        begin
            main_raw_reg <= main_mem[rd.main_idx];
            main_hit_reg <= main_valid_reg[rd.main_idx];
            main_idx_reg <= rd.main_idx;
            id_raw_reg   <= id_mem[rd.id_idx];
            id_hit_reg   <= id_valid_reg[rd.id_idx];
        end
    end

    // Valid bits: soft reset drops the main ones, only the hard reset drops the GUID ones.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        if (wr.clear_all)
        begin
            main_valid_next = '0;
        end
        if (wr.main_we)
        begin
            main_valid_next[wr.main_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= '0;
            id_valid_reg   <= '0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            if (wr.id_we)
            begin
                id_valid_reg[wr.id_idx] <= 1'b1;
            end
        end
    end

    // An entry never written since reset reads as its reset value.
    always_comb
    begin
        if (main_hit_reg)
        begin
            main_rdata = main_raw_reg;
        end
        else if (main_idx_reg == lcrf_pkg::IDX_BUS_OPT)
        begin
            main_rdata = lcrf_pkg::BUS_OPTIONS_RESET;
        end
        else
        begin
            main_rdata = '0;
        end
        id_rdata = id_hit_reg ? id_raw_reg : '0;
    end

endmodule

// ===== design/link_controller_register_file_core.sv =====
// Top level of the link controller register file: decode, read-modify-write and result register.
// Depends on lcrf_pkg, lcrf_if, lcrf_store and the assertion header.
// Flow: an accepted access item's slot is read from the register memory into registers, then the
// modify and write-back step runs once the result register is free and loads the result register;
// a new access item is taken only after the previous one has left the execute state.
// Reset: asynchronous, active low; valid bits clear at once, so no clearing pass is needed.
`include "link_controller_register_file_core_assert.svh"

module link_controller_register_file_core (
    input  logic           clk,
    input  logic           rst_n,
    lcrf_req_if.sink       req,
    lcrf_rsp_if.source     rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    lcrf_pkg::dec_t dec_now;
    lcrf_pkg::dec_t dec_reg;
    logic           write_reg;
    logic [31:0]    wdata_reg;

    lcrf_pkg::store_rd_t rd;
    lcrf_pkg::store_wr_t wr;
    logic [31:0]         main_rdata;
    logic [31:0]         id_rdata;

    logic        accept;
    logic        exec_fire;
    logic        sreset_hit;
    logic [31:0] new_value;
    logic [31:0] rd_value;

    logic [31:0] int_event_reg;
    logic [31:0] int_event_next;
    logic [31:0] int_mask_reg;
    logic [31:0] int_mask_next;
    logic        irq_calc;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_irq_reg;

    // Accept only between items; decode on the way in.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign dec_now   = lcrf_pkg::decode(req.address);

    assign rd.en       = accept;
    assign rd.main_idx = dec_now.idx;
    assign rd.id_idx   = dec_now.idx[0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg   <= dec_now;
            write_reg <= req.action;
            wdata_reg <= req.write_data;
        end
    end

    lcrf_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .wr         (wr),
        .main_rdata (main_rdata),
        .id_rdata   (id_rdata)
    );

    // The execute cycle completes once the result register is free.
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    // Soft reset is bit 16 written to the control set address.
    assign sreset_hit = write_reg && (dec_reg.kind == lcrf_pkg::K_MASK) && !dec_reg.clr
                        && (dec_reg.idx == lcrf_pkg::IDX_CONTROL)
                        && ((wdata_reg & lcrf_pkg::SOFT_RESET_BIT) != '0);

    // Modify step of the read-modify-write.
    always_comb
    begin
        if (dec_reg.kind == lcrf_pkg::K_MASK)
        begin
            if (dec_reg.clr)
            begin
                new_value = main_rdata & ~wdata_reg;
            end
            else if (sreset_hit)
            begin
                new_value = wdata_reg & ~lcrf_pkg::SOFT_RESET_BIT;
            end
            else
            begin
                new_value = main_rdata | wdata_reg;
            end
        end
        else
        begin
            new_value = wdata_reg;
        end
    end

    assign wr.main_we    = exec_fire && write_reg
                           && ((dec_reg.kind == lcrf_pkg::K_PLAIN)
                               || (dec_reg.kind == lcrf_pkg::K_MASK));
    assign wr.main_idx   = dec_reg.idx;
    assign wr.main_wdata = new_value;
    assign wr.id_we      = exec_fire && write_reg && (dec_reg.kind == lcrf_pkg::K_GUID);
    assign wr.id_idx     = dec_reg.idx[0];
    assign wr.id_wdata   = wdata_reg;
    assign wr.clear_all  = exec_fire && sreset_hit;

    // Read value; writes return zero.
    always_comb
    begin
        rd_value = '0;
        if (!write_reg)
        begin
            unique case (dec_reg.kind) inside
                lcrf_pkg::K_CONST:                   rd_value = dec_reg.value;
                lcrf_pkg::K_PLAIN, lcrf_pkg::K_MASK: rd_value = main_rdata;
                lcrf_pkg::K_GUID:                    rd_value = id_rdata;
                default:                             rd_value = '0;
            endcase
        end
    end

    // Shadow copies of the interrupt event and mask registers drive the line.
    always_comb
    begin
        int_event_next = int_event_reg;
        int_mask_next  = int_mask_reg;
        if (wr.clear_all)
        begin
            int_event_next = '0;
            int_mask_next  = '0;
        end
        if (wr.main_we && (wr.main_idx == lcrf_pkg::IDX_INT_EVENT))
        begin
            int_event_next = new_value;
        end
        if (wr.main_we && (wr.main_idx == lcrf_pkg::IDX_INT_MASK))
        begin
            int_mask_next = new_value;
        end
    end

    assign irq_calc = ((int_mask_next & lcrf_pkg::MASTER_ENABLE) != '0)
                      && ((int_event_next & int_mask_next & ~lcrf_pkg::MASTER_ENABLE) != '0);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            int_event_reg <= '0;
            int_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            int_event_reg <= int_event_next;
            int_mask_reg  <= int_mask_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_data_reg <= rd_value;
            out_irq_reg  <= irq_calc;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.irq_level = out_irq_reg;

    // Checks on the sequencing and the interrupt shadows.
    `LCRF_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `LCRF_ASSERT_NEXT(a_exec_result, clk, rst_n, exec_fire, rsp.valid)
    `LCRF_ASSERT_NEXT(a_soft_clears_irq, clk, rst_n, wr.clear_all, (int_event_reg | int_mask_reg) == '0)
    `LCRF_ASSERT_IMPLY(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !wr.main_we && !wr.id_we)

endmodule

// ===== test/link_controller_register_file_core_tb.sv =====
// Testbench for link_controller_register_file_core: a shadow of the register file predicts each
// read word and interrupt level, and a scoreboard compares them with the result items.
// Depends on lcrf_pkg, the lcrf_req_if and lcrf_rsp_if interfaces and the core itself.
module link_controller_register_file_core_tb;

    localparam int HALF_PERIOD   = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 600;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_HOLD     = 400;

    // Positions of the masks that carry special meaning.
    localparam int CONTROL_SLOT   = 0;
    localparam int INT_EVENT_SLOT = 3;
    localparam int INT_MASK_SLOT  = 4;

    localparam logic [10:0] CLEAR_OFFSET = 11'h004;
    localparam logic [10:0] RESERVED_A   = 11'h040;
    localparam logic [10:0] RESERVED_B   = 11'h0e8;

    localparam logic [10:0] FIXED_OFFSETS [8] = '{
        lcrf_pkg::ADDR_VERSION, lcrf_pkg::ADDR_BUS_NAME, lcrf_pkg::ADDR_BUS_OPTIONS,
        lcrf_pkg::ADDR_GUID_HI, lcrf_pkg::ADDR_GUID_LO, RESERVED_A, RESERVED_B,
        lcrf_pkg::ADDR_PHY_CONTROL
    };

    typedef enum logic {ACCESS_READ = 1'b0, ACCESS_WRITE = 1'b1} access_kind_t;

    typedef struct {
        logic [31:0] read_data;
        logic        irq_level;
    } reply_t;

    // Shadow copy of the register file and the replies it predicts, oldest first.
    class lcrf_access_scoreboard;
        logic [31:0] plain_regs [lcrf_pkg::NUM_PLAIN];
        logic [31:0] mask_regs [lcrf_pkg::NUM_MASKS];
        logic [31:0] opt_word;
        logic [31:0] guid_words [2];
        reply_t      expected_replies [$];
        int          error_count;

        function new();
            clear_all();
            guid_words[0] = '0;
            guid_words[1] = '0;
            error_count = 0;
        endfunction

        // Everything but the GUID words returns to its reset value.
        function void clear_all();
            foreach (plain_regs[i])
            begin
                plain_regs[i] = '0;
            end
            foreach (mask_regs[i])
            begin
                mask_regs[i] = '0;
            end
            opt_word = lcrf_pkg::BUS_OPTIONS_RESET;
        endfunction

        // Applies one accepted access to the shadow and queues the reply it must produce.
        function void note_access(access_kind_t act, logic [10:0] a, logic [31:0] d);
            int          p;
            int          m;
            logic [31:0] v;
            logic [31:0] rd;
            logic [31:0] pending_events;
            reply_t      r;
            p  = -1;
            m  = -1;
            v  = d;
            rd = '0;
            for (int i = 0; i < lcrf_pkg::NUM_PLAIN; i++)
            begin
                if (a == lcrf_pkg::PLAIN_OFFSETS[i])
                    p = i;
            end
            for (int i = 0; i < lcrf_pkg::NUM_MASKS; i++)
            begin
                if ((a & ~CLEAR_OFFSET) == lcrf_pkg::MASK_OFFSETS[i])
                    m = i;
            end
            if (act == ACCESS_WRITE)
            begin
                if (p >= 0)
                    plain_regs[p] = v;
                else if (m >= 0)
                begin
                    if (a[2])
                        mask_regs[m] &= ~v;
                    else
                    begin
                        // A soft reset comes first; the rest of the word is then ORed in.
                        if (m == CONTROL_SLOT && (v & lcrf_pkg::SOFT_RESET_BIT) != '0)
                        begin
                            clear_all();
                            v &= ~lcrf_pkg::SOFT_RESET_BIT;
                        end
                        mask_regs[m] |= v;
                    end
                end
                else if (a == lcrf_pkg::ADDR_BUS_OPTIONS)
                    opt_word = v;
                else if (a == lcrf_pkg::ADDR_GUID_HI)
                    guid_words[0] = v;
                else if (a == lcrf_pkg::ADDR_GUID_LO)
                    guid_words[1] = v;
            end
            else
            begin
                if (p >= 0)
                    rd = plain_regs[p];
                else if (m >= 0)
                    rd = mask_regs[m];
                else
                begin
                    case (a)
                        lcrf_pkg::ADDR_VERSION:     rd = lcrf_pkg::VERSION_WORD;
                        lcrf_pkg::ADDR_BUS_NAME:    rd = lcrf_pkg::BUS_NAME_WORD;
                        lcrf_pkg::ADDR_BUS_OPTIONS: rd = opt_word;
                        lcrf_pkg::ADDR_GUID_HI:     rd = guid_words[0];
                        lcrf_pkg::ADDR_GUID_LO:     rd = guid_words[1];
                        lcrf_pkg::ADDR_PHY_CONTROL: rd = lcrf_pkg::PHY_ABSENT;
                        default:                    rd = '0;
                    endcase
                end
            end
            // The master bit gates the line but never counts as an event itself.
            pending_events = mask_regs[INT_EVENT_SLOT] & mask_regs[INT_MASK_SLOT]
                             & ~lcrf_pkg::MASTER_ENABLE;
            r.read_data = rd;
            r.irq_level = ((mask_regs[INT_MASK_SLOT] & lcrf_pkg::MASTER_ENABLE) != '0)
                          && (pending_events != '0);
            expected_replies.push_back(r);
        endfunction

        // Compares one result item with the oldest predicted reply.
        function void check_reply(logic [31:0] rd, logic irq);
            reply_t e;
            if (expected_replies.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual read_data %h irq_level %b",
                         $time, rd, irq);
                return;
            end
            e = expected_replies.pop_front();
            if (rd !== e.read_data)
            begin
                error_count++;
                $display("%0t: read_data mismatch, expected %h, actual %h",
                         $time, e.read_data, rd);
            end
            if (irq !== e.irq_level)
            begin
                error_count++;
                $display("%0t: irq_level mismatch, expected %b, actual %b",
                         $time, e.irq_level, irq);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_request;
    int   cycle_count;

    lcrf_access_scoreboard board;

    lcrf_req_if req_ch ();
    lcrf_rsp_if rsp_ch ();

    link_controller_register_file_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Offers one access item from a falling edge and returns at the falling edge after
    // it has been accepted.
    task automatic drive_access(access_kind_t act, logic [10:0] a, logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.action     = act;
        req_ch.address    = a;
        req_ch.write_data = d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_access(act, a, d);
        @(negedge clk);
    endtask

    // Mostly decoded offsets with random content, the rest anywhere in the window.
    task automatic random_access();
        logic [10:0]  a;
        logic [31:0]  d;
        access_kind_t act;
        int           sel;
        sel = $urandom_range(99);
        if (sel < 30)
            a = lcrf_pkg::PLAIN_OFFSETS[$urandom_range(lcrf_pkg::NUM_PLAIN - 1)];
        else if (sel < 55)
            a = lcrf_pkg::MASK_OFFSETS[$urandom_range(lcrf_pkg::NUM_MASKS - 1)]
                | ($urandom_range(1) ? CLEAR_OFFSET : 11'h000);
        else if (sel < 70)
            a = lcrf_pkg::MASK_OFFSETS[$urandom_range(1) ? INT_EVENT_SLOT : INT_MASK_SLOT]
                | ($urandom_range(1) ? CLEAR_OFFSET : 11'h000);
        else if (sel < 82)
            a = FIXED_OFFSETS[$urandom_range(7)];
        else
            a = 11'($urandom_range(2047));
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = '1;
            2:       d = 32'h1 << $urandom_range(31);
            default: d = $urandom;
        endcase
        // Keep soft resets occasional so that state can build up between them.
        if (a == lcrf_pkg::MASK_OFFSETS[CONTROL_SLOT] && $urandom_range(3) != 0)
            d &= ~lcrf_pkg::SOFT_RESET_BIT;
        act = $urandom_range(1) ? ACCESS_WRITE : ACCESS_READ;
        drive_access(act, a, d);
    endtask

    // Lowers valid and waits at falling edges until every predicted reply has come.
    task automatic wait_for_replies();
        req_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result items are taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_reply(rsp_ch.read_data, rsp_ch.irq_level);
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("link_controller_register_file_core_tb: errors");
            $finish;
        end
    end

    // Reset, directed accesses, then three random phases with different idling.
    initial
    begin
        board             = new();
        cycle_count       = 0;
        hold_request      = 0;
        send_idle_pct     = 34;
        recv_idle_pct     = 54;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACCESS_READ;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fixed words, reset values and reserved offsets, then writes to fixed, GUID, option and plain words.
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_VERSION, '0);
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_BUS_NAME, '0);
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_BUS_OPTIONS, '0);
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_PHY_CONTROL, '0);
        drive_access(ACCESS_READ, RESERVED_A, '1);
        drive_access(ACCESS_READ, RESERVED_B, '0);
        drive_access(ACCESS_WRITE, lcrf_pkg::ADDR_VERSION, 32'hdead_beef);
        drive_access(ACCESS_WRITE, lcrf_pkg::ADDR_GUID_HI, '1);
        drive_access(ACCESS_WRITE, lcrf_pkg::ADDR_GUID_LO, 32'h1234_5678);
        drive_access(ACCESS_WRITE, lcrf_pkg::ADDR_BUS_OPTIONS, '1);
        drive_access(ACCESS_WRITE, lcrf_pkg::PLAIN_OFFSETS[0], '1);
        drive_access(ACCESS_WRITE, lcrf_pkg::PLAIN_OFFSETS[lcrf_pkg::NUM_PLAIN - 1],
                     32'h8000_0001);

        // Interrupt line: raised by an unmasked event, dropped by clearing it, and not
        // raised by the master bit standing in the event register.
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[INT_MASK_SLOT], 32'h8000_0001);
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[INT_EVENT_SLOT], 32'h0000_0001);
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[INT_EVENT_SLOT] | CLEAR_OFFSET, '1);
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[INT_EVENT_SLOT],
                     lcrf_pkg::MASTER_ENABLE);

        // Unaligned and top-of-window offsets read zero and ignore writes.
        drive_access(ACCESS_WRITE, 11'h051, '1);
        drive_access(ACCESS_READ, 11'h051, '0);
        drive_access(ACCESS_WRITE, 11'h7fc, '1);
        drive_access(ACCESS_READ, 11'h7ff, '0);

        // The clear address never resets; the set address with the reset bit does.
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[CONTROL_SLOT] | CLEAR_OFFSET,
                     lcrf_pkg::SOFT_RESET_BIT);
        drive_access(ACCESS_WRITE, lcrf_pkg::MASK_OFFSETS[CONTROL_SLOT], '1);
        drive_access(ACCESS_READ, lcrf_pkg::MASK_OFFSETS[CONTROL_SLOT] | CLEAR_OFFSET, '0);
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_GUID_HI, '0);
        drive_access(ACCESS_READ, lcrf_pkg::ADDR_BUS_OPTIONS, '0);
        wait_for_replies();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 34 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Long result stall while items keep coming, so the core backs up.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    hold_request = LONG_HOLD;
                random_access();
            end
            wait_for_replies();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("link_controller_register_file_core_tb: clean");
        else
            $display("link_controller_register_file_core_tb: errors");
        $finish;
    end

endmodule
